@@ hw/rtl/bmpd_pkg.sv @@
// ----------------------------------------------------------------------------
// bmpd_pkg
// Shared types and codes of the bitmap-mode pixel decoder: display modes,
// color kinds, request structs and the payload of each pipeline stage.
// ----------------------------------------------------------------------------
package bmpd_pkg;

  // Display mode register
  typedef logic [2:0] mode_t;

  localparam mode_t MODE_NIBBLE  = 3'd0;
  localparam mode_t MODE_TWO_BIT = 3'd1;
  localparam mode_t MODE_PLANAR  = 3'd2;
  localparam mode_t MODE_DIRECT  = 3'd3;
  localparam mode_t MODE_YJK     = 3'd4;
  localparam mode_t MODE_YJK_ESC = 3'd5;
  localparam mode_t MODE_NONE    = 3'd6;

  // Color kind of one pixel
  typedef logic [1:0] kind_t;

  localparam kind_t KIND_PALETTE = 2'd0;
  localparam kind_t KIND_DIRECT  = 2'd1;
  localparam kind_t KIND_RGB     = 2'd2;

  // Pixel count of one request
  typedef logic [4:0] count_t;

  localparam count_t COUNT_QUAD  = 5'd4;
  localparam count_t COUNT_OCTET = 5'd8;
  localparam count_t COUNT_FULL  = 5'd16;

  // Two-bit mode: odd pixels use the upper palette bank
  localparam logic [4:0] PAL_BANK_HI = 5'd16;
  // YJK escape flag in each byte
  localparam int ESC_BIT = 3;

  // Input request
  typedef struct packed {
    logic [7:0] byte_0;
    logic [7:0] byte_1;
    logic [7:0] byte_2;
    logic [7:0] byte_3;
  } in_item_t;

  // Result request
  typedef struct packed {
    kind_t       color_kind;
    logic [14:0] color_value;
    logic        last_pixel;
  } out_item_t;

  // Stage 1: bytes plus the shared chroma pair
  typedef struct packed {
    logic [3:0][7:0] pix_byte;
    mode_t           mode;
    logic [5:0]      chroma_j;
    logic [5:0]      chroma_k;
  } s1_t;

  // Stage 2: unclipped color terms per lane
  typedef struct packed {
    logic [3:0][7:0] pix_byte;
    mode_t           mode;
    logic [3:0][6:0] red_raw;
    logic [3:0][6:0] grn_raw;
    logic [3:0][9:0] blu_num;
  } s2_t;

  // One pixel before it gets its last flag
  typedef struct packed {
    kind_t       kind;
    logic [14:0] value;
  } pix_t;

  // Stage 3: pixel list in screen order, entry 0 first
  typedef struct packed {
    pix_t [15:0] pix;
    count_t      count;
  } s3_t;

endpackage

@@ hw/rtl/bmpd_chroma.sv @@
// ----------------------------------------------------------------------------
// bmpd_chroma
// First pipeline stage: capture the four bytes and the mode, and form the
// signed 6-bit chroma pair J and K.
// ----------------------------------------------------------------------------
module bmpd_chroma (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              up_valid,
  output logic              up_ready,
  input  bmpd_pkg::in_item_t up_data,
  input  bmpd_pkg::mode_t   up_mode,
  output logic              dn_valid,
  input  logic              dn_ready,
  output bmpd_pkg::s1_t     dn_data
);
  import bmpd_pkg::*;

  logic valid_r;
  s1_t  data_r;
  s1_t  data_nxt;

  // Advance when the stage is empty or the next one takes the request
  assign up_ready = !valid_r || dn_ready;

  // Unpack bytes; K from bytes 0/1, J from bytes 2/3 (low three bits each)
  always_comb begin
    data_nxt.pix_byte[0] = up_data.byte_0;
    data_nxt.pix_byte[1] = up_data.byte_1;
    data_nxt.pix_byte[2] = up_data.byte_2;
    data_nxt.pix_byte[3] = up_data.byte_3;
    data_nxt.mode        = up_mode;
    data_nxt.chroma_k    = {up_data.byte_1[2:0], up_data.byte_0[2:0]};
    data_nxt.chroma_j    = {up_data.byte_3[2:0], up_data.byte_2[2:0]};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      data_r <= data_nxt;
    end
  end

  assign dn_valid = valid_r;
  assign dn_data  = data_r;

endmodule

@@ hw/rtl/bmpd_color.sv @@
// ----------------------------------------------------------------------------
// bmpd_color
// Second pipeline stage: per pixel lane, form the unclipped YJK terms
// y + J, y + K and the blue numerator 5y - 2J - K.
// ----------------------------------------------------------------------------
module bmpd_color (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          up_valid,
  output logic          up_ready,
  input  bmpd_pkg::s1_t up_data,
  output logic          dn_valid,
  input  logic          dn_ready,
  output bmpd_pkg::s2_t dn_data
);
  import bmpd_pkg::*;

  logic valid_r;
  s2_t  data_r;
  s2_t  data_nxt;

  assign up_ready = !valid_r || dn_ready;

  // Four independent lanes
  always_comb begin
    logic        [4:0] luma;
    logic signed [6:0] j7;
    logic signed [6:0] k7;
    logic signed [9:0] j10;
    logic signed [9:0] k10;
    logic signed [9:0] y10;
    j7  = 7'($signed(up_data.chroma_j));
    k7  = 7'($signed(up_data.chroma_k));
    j10 = 10'($signed(up_data.chroma_j));
    k10 = 10'($signed(up_data.chroma_k));
    data_nxt.pix_byte = up_data.pix_byte;
    data_nxt.mode     = up_data.mode;
    for (int n = 0; n < 4; n++) begin
      luma = up_data.pix_byte[n][7:3];
      y10  = $signed({5'b0, luma});
      data_nxt.red_raw[n] = 7'($signed({2'b0, luma}) + j7);
      data_nxt.grn_raw[n] = 7'($signed({2'b0, luma}) + k7);
      data_nxt.blu_num[n] = 10'((y10 <<< 2) + y10 - (j10 <<< 1) - k10);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      data_r <= data_nxt;
    end
  end

  assign dn_valid = valid_r;
  assign dn_data  = data_r;

endmodule

@@ hw/rtl/bmpd_pix.sv @@
// ----------------------------------------------------------------------------
// bmpd_pix
// Third pipeline stage: divide the blue term, clip the components and build
// the pixel list in screen order for the captured mode.
// ----------------------------------------------------------------------------
module bmpd_pix (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          up_valid,
  output logic          up_ready,
  input  bmpd_pkg::s2_t up_data,
  output logic          dn_valid,
  input  logic          dn_ready,
  output bmpd_pkg::s3_t dn_data
);
  import bmpd_pkg::*;

  logic valid_r;
  s3_t  data_r;
  s3_t  data_nxt;

  // Limit a signed term to 0..31
  function automatic logic [4:0] clip5(input logic signed [9:0] v);
    logic [4:0] res;
    if (v < 10'sd0) begin
      res = 5'd0;
    end else if (v > 10'sd31) begin
      res = 5'd31;
    end else begin
      res = v[4:0];
    end
    return res;
  endfunction

  assign up_ready = !valid_r || dn_ready;

  // Build the list
  always_comb begin
    logic signed [9:0] num;
    logic signed [9:0] quo;
    logic        [7:0] pb;
    logic        [4:0] red;
    logic        [4:0] grn;
    logic        [4:0] blu;
    pb             = '0;
    num            = '0;
    quo            = '0;
    red            = '0;
    grn            = '0;
    blu            = '0;
    data_nxt.pix   = '0;
    data_nxt.count = COUNT_QUAD;
    case (up_data.mode)
      MODE_NIBBLE, MODE_PLANAR: begin
        data_nxt.count = COUNT_OCTET;
        for (int n = 0; n < 4; n++) begin
          data_nxt.pix[2*n].kind    = KIND_PALETTE;
          data_nxt.pix[2*n].value   = {11'b0, up_data.pix_byte[n][7:4]};
          data_nxt.pix[2*n+1].kind  = KIND_PALETTE;
          data_nxt.pix[2*n+1].value = {11'b0, up_data.pix_byte[n][3:0]};
        end
      end
      MODE_TWO_BIT: begin
        data_nxt.count = COUNT_FULL;
        for (int n = 0; n < 4; n++) begin
          pb = up_data.pix_byte[n];
          data_nxt.pix[4*n].kind    = KIND_PALETTE;
          data_nxt.pix[4*n].value   = {13'b0, pb[7:6]};
          data_nxt.pix[4*n+1].kind  = KIND_PALETTE;
          data_nxt.pix[4*n+1].value = {10'b0, PAL_BANK_HI | {3'b0, pb[5:4]}};
          data_nxt.pix[4*n+2].kind  = KIND_PALETTE;
          data_nxt.pix[4*n+2].value = {13'b0, pb[3:2]};
          data_nxt.pix[4*n+3].kind  = KIND_PALETTE;
          data_nxt.pix[4*n+3].value = {10'b0, PAL_BANK_HI | {3'b0, pb[1:0]}};
        end
      end
      MODE_DIRECT: begin
        for (int n = 0; n < 4; n++) begin
          data_nxt.pix[n].kind  = KIND_DIRECT;
          data_nxt.pix[n].value = {7'b0, up_data.pix_byte[n]};
        end
      end
      MODE_YJK, MODE_YJK_ESC: begin
        for (int n = 0; n < 4; n++) begin
          pb  = up_data.pix_byte[n];
          num = $signed(up_data.blu_num[n]);
          // Divide by four, truncating toward zero
          quo = (num + (num[9] ? 10'sd3 : 10'sd0)) >>> 2;
          red = clip5(10'($signed(up_data.red_raw[n])));
          grn = clip5(10'($signed(up_data.grn_raw[n])));
          blu = clip5(quo);
          if (up_data.mode == MODE_YJK_ESC && pb[ESC_BIT]) begin
            data_nxt.pix[n].kind  = KIND_PALETTE;
            data_nxt.pix[n].value = {11'b0, pb[7:4]};
          end else begin
            data_nxt.pix[n].kind  = KIND_RGB;
            data_nxt.pix[n].value = {red, grn, blu};
          end
        end
      end
      default: begin
        // Unsupported mode: four pixels of palette entry 0
        data_nxt.count = COUNT_QUAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      data_r <= data_nxt;
    end
  end

  assign dn_valid = valid_r;
  assign dn_data  = data_r;

endmodule

@@ hw/rtl/bmpd_serial.sv @@
// ----------------------------------------------------------------------------
// bmpd_serial
// Pixel shifter and output register: loads one pixel list, hands out one pixel
// per cycle while out_stall is low and flags the last pixel of each request.
// ----------------------------------------------------------------------------
module bmpd_serial (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                up_valid,
  output logic                up_ready,
  input  bmpd_pkg::s3_t       up_data,
  output logic                out_valid,
  input  logic                out_stall,
  output bmpd_pkg::out_item_t out_data
);
  import bmpd_pkg::*;

  pix_t [15:0] list_r;
  pix_t [15:0] list_nxt;
  count_t      cnt_r;
  count_t      cnt_nxt;
  logic        out_valid_r;
  logic        out_valid_nxt;
  out_item_t   out_r;
  out_item_t   out_nxt;
  logic        out_free;
  logic        pop;
  logic        load;

  // Output register can take a pixel
  assign out_free = !out_valid_r || !out_stall;
  assign pop      = out_free && (cnt_r != '0);
  // Take the next list as the last pixel of the current one leaves
  assign up_ready = (cnt_r == '0) || ((cnt_r == 5'd1) && out_free);
  assign load     = up_valid && up_ready;

  // Shift the list, count down, fill the output register
  always_comb begin
    list_nxt      = list_r;
    cnt_nxt       = cnt_r;
    out_nxt       = out_r;
    out_valid_nxt = out_free ? (cnt_r != '0) : out_valid_r;
    if (pop) begin
      out_nxt.color_kind  = list_r[0].kind;
      out_nxt.color_value = list_r[0].value;
      out_nxt.last_pixel  = (cnt_r == 5'd1);
      for (int i = 0; i < 15; i++) begin
        list_nxt[i] = list_r[i+1];
      end
      list_nxt[15] = '0;
      cnt_nxt      = cnt_r - 5'd1;
    end
    if (load) begin
      list_nxt = up_data.pix;
      cnt_nxt  = up_data.count;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    list_r <= list_nxt;
    out_r  <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

@@ hw/rtl/bitmap_mode_pixel_decoder_core.sv @@
// Path: chroma, color-term and pixel-list registers, then the pixel shifter.
// Throughput: one pixel per cycle while out_stall is low; a request yields 4
// pixels (direct, YJK and unsupported modes), 8 (nibble modes) or 16 (two-bit
// mode), set by the pixel shifter that feeds the output register.
// Reset: synchronous, active low; empties all stages, mode returns to nibble.
// ----------------------------------------------------------------------------
// bitmap_mode_pixel_decoder_core
// Bitmap-mode pixel decoder: three compute stages (chroma, color terms,
// pixel list) followed by a pixel shifter with an output register.
// ----------------------------------------------------------------------------
module bitmap_mode_pixel_decoder_core (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  bmpd_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output bmpd_pkg::out_item_t out_data,
  input  logic                cfg_we,
  input  bmpd_pkg::mode_t     cfg_wdata
);
  import bmpd_pkg::*;

  mode_t mode_r;
  logic  s1_ready;
  logic  s1_valid;
  s1_t   s1_data;
  logic  s2_ready;
  logic  s2_valid;
  s2_t   s2_data;
  logic  s3_ready;
  logic  s3_valid;
  s3_t   s3_data;
  logic  ser_ready;

  // Display mode register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_NIBBLE;
    end else if (cfg_we) begin
      mode_r <= cfg_wdata;
    end
  end

  assign in_stall = !s1_ready;

  bmpd_chroma u_chroma (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (in_valid),
    .up_ready (s1_ready),
    .up_data  (in_data),
    .up_mode  (mode_r),
    .dn_valid (s1_valid),
    .dn_ready (s2_ready),
    .dn_data  (s1_data)
  );

  bmpd_color u_color (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (s1_valid),
    .up_ready (s2_ready),
    .up_data  (s1_data),
    .dn_valid (s2_valid),
    .dn_ready (s3_ready),
    .dn_data  (s2_data)
  );

  bmpd_pix u_pix (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (s2_valid),
    .up_ready (s3_ready),
    .up_data  (s2_data),
    .dn_valid (s3_valid),
    .dn_ready (ser_ready),
    .dn_data  (s3_data)
  );

  bmpd_serial u_serial (
    .clk       (clk),
    .rst_n     (rst_n),
    .up_valid  (s3_valid),
    .up_ready  (ser_ready),
    .up_data   (s3_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

@@ hw/rtl/bmpd_checker.sv @@
// ----------------------------------------------------------------------------
// bmpd_checker
// Port-level checks of the pixel decoder, bound to the top level.
// ----------------------------------------------------------------------------
module bmpd_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                out_valid,
  input logic                out_stall,
  input bmpd_pkg::out_item_t out_data
);
  import bmpd_pkg::*;

  // Reset empties the output
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("out_valid high after reset");

  // A stalled pixel holds
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled pixel changed");

  // Palette pixels index 0..31
  a_palette_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.color_kind == KIND_PALETTE |-> out_data.color_value[14:5] == '0)
    else $error("palette index out of range");

  // Direct pixels are one byte
  a_direct_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.color_kind == KIND_DIRECT |-> out_data.color_value[14:8] == '0)
    else $error("direct color wider than a byte");

endmodule

bind bitmap_mode_pixel_decoder_core bmpd_checker u_bmpd_checker (.*);
